// ===== rtl/core/hct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_pkg
// Shared types, widths, control word layout and microcode for the cubic
// Hermite curve tessellator.
// ----------------------------------------------------------------------------
package hct_pkg;

  localparam int COORD_W   = 16;              // signed Q4.12 coordinate
  localparam int FRAC_W    = 16;              // unsigned Q0.16 curve parameter
  localparam int SEG_W     = 7;               // segment count register width
  localparam int WGT_W     = FRAC_W + 3;      // signed basis weight
  localparam int MB_W      = COORD_W + 1;     // second multiplier operand
  localparam int PROD_W    = WGT_W + MB_W;    // product width
  localparam int ACC_W     = PROD_W + 2;      // four-term sum
  localparam int DIV_N_W   = FRAC_W + 1;      // dividend is one in Q.16
  localparam int DIV_CNT_W = 5;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [SEG_W-1:0] MAX_SEGMENTS  = 7'd64;
  localparam logic [SEG_W-1:0] SEG_RESET     = 7'd16;
  localparam logic [SEG_W-1:0] SEG_MIN       = 7'd2;
  localparam logic [0:0]       REG_SEG_COUNT = 1'b0;

  // microcode steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] ST_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] ST_DINIT = 4'd1;
  localparam logic [STEP_W-1:0] ST_DIV   = 4'd2;
  localparam logic [STEP_W-1:0] ST_TSTEP = 4'd3;
  localparam logic [STEP_W-1:0] ST_MTT   = 4'd4;
  localparam logic [STEP_W-1:0] ST_LT2   = 4'd5;
  localparam logic [STEP_W-1:0] ST_MT2T  = 4'd6;
  localparam logic [STEP_W-1:0] ST_LT3   = 4'd7;
  localparam logic [STEP_W-1:0] ST_LW    = 4'd8;
  localparam logic [STEP_W-1:0] ST_MW0   = 4'd9;
  localparam logic [STEP_W-1:0] ST_MW1   = 4'd10;
  localparam logic [STEP_W-1:0] ST_MW2   = 4'd11;
  localparam logic [STEP_W-1:0] ST_MW3   = 4'd12;
  localparam logic [STEP_W-1:0] ST_ACC   = 4'd13;
  localparam logic [STEP_W-1:0] ST_EMIT  = 4'd14;

  // jump conditions
  localparam logic [2:0] J_NEXT  = 3'd0;
  localparam logic [2:0] J_GOTO  = 3'd1;
  localparam logic [2:0] J_START = 3'd2;
  localparam logic [2:0] J_LOOP  = 3'd3;
  localparam logic [2:0] J_EMIT  = 3'd4;

  // multiplier operand selects
  localparam logic [2:0] M_TT  = 3'd0;
  localparam logic [2:0] M_T2T = 3'd1;
  localparam logic [2:0] M_W0  = 3'd2;
  localparam logic [2:0] M_W1  = 3'd3;
  localparam logic [2:0] M_W2  = 3'd4;
  localparam logic [2:0] M_W3  = 3'd5;

  // accumulator ops
  localparam logic [1:0] A_HOLD = 2'd0;
  localparam logic [1:0] A_LOAD = 2'd1;
  localparam logic [1:0] A_ADD  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_dx;
    logic signed [COORD_W-1:0] start_dy;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_dx;
    logic signed [COORD_W-1:0] end_dy;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } out_item_t;

  typedef struct packed {
    logic              idle;
    logic              div_init;
    logic              div_step;
    logic              t_step;
    logic              t2_ld;
    logic              t3_ld;
    logic              w_ld;
    logic              mul_en;
    logic [2:0]        msel;
    logic [1:0]        acc_op;
    logic              emit;
    logic [2:0]        jcond;
    logic [STEP_W-1:0] target;
  } ctl_t;

  typedef struct packed {
    logic start_ok;
    logic loop_done;
    logic out_free;
    logic last;
  } sts_t;

  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '0;
    w.jcond  = J_NEXT;
    w.msel   = M_TT;
    w.acc_op = A_HOLD;
    unique case (step)
      ST_IDLE: begin
        w.idle   = 1'b1;
        w.jcond  = J_START;
        w.target = ST_IDLE;
      end
      ST_DINIT: w.div_init = 1'b1;
      ST_DIV: begin
        w.div_step = 1'b1;
        w.jcond    = J_LOOP;
        w.target   = ST_DIV;
      end
      ST_TSTEP: w.t_step = 1'b1;
      ST_MTT: begin
        w.mul_en = 1'b1;
        w.msel   = M_TT;
      end
      ST_LT2: w.t2_ld = 1'b1;
      ST_MT2T: begin
        w.mul_en = 1'b1;
        w.msel   = M_T2T;
      end
      ST_LT3: w.t3_ld = 1'b1;
      ST_LW:  w.w_ld  = 1'b1;
      ST_MW0: begin
        w.mul_en = 1'b1;
        w.msel   = M_W0;
      end
      ST_MW1: begin
        w.mul_en = 1'b1;
        w.msel   = M_W1;
        w.acc_op = A_LOAD;
      end
      ST_MW2: begin
        w.mul_en = 1'b1;
        w.msel   = M_W2;
        w.acc_op = A_ADD;
      end
      ST_MW3: begin
        w.mul_en = 1'b1;
        w.msel   = M_W3;
        w.acc_op = A_ADD;
      end
      ST_ACC: w.acc_op = A_ADD;
      ST_EMIT: begin
        w.emit   = 1'b1;
        w.jcond  = J_EMIT;
        w.target = ST_TSTEP;
      end
      default: begin
        w.jcond  = J_GOTO;
        w.target = ST_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/hct_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_sequencer
// Step counter over the microcode store, with conditional jumps on datapath
// status.
// ----------------------------------------------------------------------------
module hct_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  input  hct_pkg::sts_t sts,
  output hct_pkg::ctl_t ctl
);
  import hct_pkg::*;

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [STEP_W-1:0] step_inc;

  assign ctl      = ucode(step_r);
  assign step_inc = step_r + 1'b1;

  always_comb begin
    unique case (ctl.jcond)
      J_NEXT:  step_nxt = step_inc;
      J_GOTO:  step_nxt = ctl.target;
      J_START: step_nxt = sts.start_ok ? step_inc : ctl.target;
      J_LOOP:  step_nxt = sts.loop_done ? step_inc : ctl.target;
      // hold until the output register frees up, then loop or finish
      J_EMIT: begin
        if (!sts.out_free) begin
          step_nxt = step_r;
        end else if (sts.last) begin
          step_nxt = ST_IDLE;
        end else begin
          step_nxt = ctl.target;
        end
      end
      default: step_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== rtl/core/hct_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hct_datapath
// Reciprocal divider, curve parameter stepper, shared multiplier pair,
// accumulators and output register, driven by the microcode control word.
// ----------------------------------------------------------------------------
module hct_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  hct_pkg::ctl_t               ctl,
  input  logic                        in_valid,
  input  hct_pkg::in_item_t           in_data,
  input  logic [hct_pkg::SEG_W-1:0]   seg_count,
  input  logic                        out_stall,
  output hct_pkg::sts_t               sts,
  output logic                        out_valid,
  output hct_pkg::out_item_t          out_data
);
  import hct_pkg::*;

  function automatic logic signed [COORD_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] sh;
    logic signed [COORD_W-1:0] r;
    s  = acc + ACC_W'(32768);
    sh = s >>> FRAC_W;
    if (sh > ACC_W'(32767)) begin
      r = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (sh < -ACC_W'(32768)) begin
      r = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      r = sh[COORD_W-1:0];
    end
    return r;
  endfunction

  in_item_t                  in_r;
  logic [SEG_W-1:0]          n_r;
  // divider for one over n: quotient and remainder per step of t
  logic [SEG_W-1:0]          rem_r;
  logic [FRAC_W-1:0]         quo_r;
  logic [DIV_N_W-1:0]        num_r;
  logic [DIV_CNT_W-1:0]      cnt_r;
  logic [SEG_W:0]            trial;
  logic                      trial_ge;
  // t = round(i/n) kept as quotient plus remainder
  logic [FRAC_W-1:0]         t_r;
  logic [SEG_W-1:0]          frac_r;
  logic [SEG_W-1:0]          idx_r;
  logic [SEG_W:0]            frac_sum;
  logic                      frac_wrap;
  logic [FRAC_W-1:0]         t2_r;
  logic [FRAC_W-1:0]         t3_r;
  logic [31:0]               round_sum;
  logic signed [WGT_W-1:0]   h00_r, h10_r, h01_r, h11_r;
  logic signed [WGT_W-1:0]   e_t, e_t2_1, e_t3_1, e_t2;
  logic signed [WGT_W-1:0]   mul_a;
  logic signed [MB_W-1:0]    mul_bx, mul_by;
  logic signed [PROD_W-1:0]  prod_x_r, prod_y_r;
  logic signed [ACC_W-1:0]   acc_x_r, acc_y_r;
  logic                      out_valid_r;
  out_item_t                 out_r;
  logic                      out_free;
  logic                      last;

  assign trial    = {rem_r, num_r[DIV_N_W-1]};
  assign trial_ge = trial >= {1'b0, n_r};

  assign frac_sum  = {1'b0, frac_r} + {1'b0, rem_r};
  assign frac_wrap = frac_sum >= {1'b0, n_r};

  assign round_sum = prod_x_r[31:0] + 32'd32768;

  // t values zero-extended, some doubled, for the basis weights
  assign e_t    = {3'b000, t_r};
  assign e_t2   = {3'b000, t2_r};
  assign e_t2_1 = {2'b00, t2_r, 1'b0};
  assign e_t3_1 = {2'b00, t3_r, 1'b0};

  always_comb begin
    case (ctl.msel)
      M_TT: begin
        mul_a  = e_t;
        mul_bx = {1'b0, t_r};
        mul_by = '0;
      end
      M_T2T: begin
        mul_a  = e_t2;
        mul_bx = {1'b0, t_r};
        mul_by = '0;
      end
      M_W0: begin
        mul_a  = h00_r;
        mul_bx = {in_r.start_x[COORD_W-1], in_r.start_x};
        mul_by = {in_r.start_y[COORD_W-1], in_r.start_y};
      end
      M_W1: begin
        mul_a  = h10_r;
        mul_bx = {in_r.start_dx[COORD_W-1], in_r.start_dx};
        mul_by = {in_r.start_dy[COORD_W-1], in_r.start_dy};
      end
      M_W2: begin
        mul_a  = h01_r;
        mul_bx = {in_r.end_x[COORD_W-1], in_r.end_x};
        mul_by = {in_r.end_y[COORD_W-1], in_r.end_y};
      end
      M_W3: begin
        mul_a  = h11_r;
        mul_bx = {in_r.end_dx[COORD_W-1], in_r.end_dx};
        mul_by = {in_r.end_dy[COORD_W-1], in_r.end_dy};
      end
      default: begin
        mul_a  = '0;
        mul_bx = '0;
        mul_by = '0;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;
  assign last     = idx_r == (n_r - 1'b1);

  assign sts.start_ok  = in_valid && (seg_count >= SEG_MIN);
  assign sts.loop_done = cnt_r == '0;
  assign sts.out_free  = out_free;
  assign sts.last      = last;

  always_ff @(posedge clk) begin
    if (ctl.idle && in_valid) begin
      in_r <= in_data;
      n_r  <= seg_count;
    end
    if (ctl.div_init) begin
      rem_r  <= '0;
      quo_r  <= '0;
      num_r  <= {1'b1, {(DIV_N_W-1){1'b0}}};
      cnt_r  <= DIV_CNT_W'(DIV_N_W - 1);
      t_r    <= '0;
      frac_r <= n_r >> 1;
      idx_r  <= '0;
    end
    if (ctl.div_step) begin
      rem_r <= trial_ge ? SEG_W'(trial - {1'b0, n_r}) : trial[SEG_W-1:0];
      quo_r <= {quo_r[FRAC_W-2:0], trial_ge};
      num_r <= {num_r[DIV_N_W-2:0], 1'b0};
      cnt_r <= cnt_r - 1'b1;
    end
    if (ctl.t_step) begin
      frac_r <= frac_wrap ? SEG_W'(frac_sum - {1'b0, n_r}) : frac_sum[SEG_W-1:0];
      t_r    <= t_r + quo_r + FRAC_W'(frac_wrap);
      idx_r  <= idx_r + 1'b1;
    end
    if (ctl.t2_ld) begin
      t2_r <= round_sum[31:16];
    end
    if (ctl.t3_ld) begin
      t3_r <= round_sum[31:16];
    end
    if (ctl.w_ld) begin
      h00_r <= e_t3_1 - e_t2_1 - e_t2 + WGT_W'(65536);
      h10_r <= {3'b000, t3_r} - e_t2_1 + e_t;
      h01_r <= e_t2_1 + e_t2 - e_t3_1;
      h11_r <= {3'b000, t3_r} - e_t2;
    end
    if (ctl.mul_en) begin
      prod_x_r <= mul_a * mul_bx;
      prod_y_r <= mul_a * mul_by;
    end
    case (ctl.acc_op)
      A_LOAD: begin
        acc_x_r <= ACC_W'(prod_x_r);
        acc_y_r <= ACC_W'(prod_y_r);
      end
      A_ADD: begin
        acc_x_r <= acc_x_r + ACC_W'(prod_x_r);
        acc_y_r <= acc_y_r + ACC_W'(prod_y_r);
      end
      default: begin
        acc_x_r <= acc_x_r;
        acc_y_r <= acc_y_r;
      end
    endcase
    if (ctl.emit && out_free) begin
      out_r.point_x    <= finish(acc_x_r);
      out_r.point_y    <= finish(acc_y_r);
      out_r.last_point <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/hermite_curve_tessellator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_curve_tessellator
// Cubic Hermite curve tessellator: one request of two points and two
// tangents gives the N-1 interior curve points at t = i/N.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  in_       input      in_valid / in_stall       in_item_t (8 x Q4.12)
//  out_      output     out_valid / out_stall     out_item_t (x, y, last)
//  apb       input      psel/penable/pwrite/ready segment_count at 0x0
//
//  a request runs the radix-2 divider forming 1/N, then 12 microcode
//  steps per point on the shared multiplier pair and accumulators
//  one request at a time; in_stall is low only in the idle step
//  a stalled output holds the sequencer in its emit step
//  synchronous active-low reset sets segment_count to 16
// ----------------------------------------------------------------------------
module hermite_curve_tessellator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  hct_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output hct_pkg::out_item_t            out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [hct_pkg::ADDR_W-1:0]    paddr,
  input  logic [hct_pkg::DATA_W-1:0]    pwdata,
  output logic [hct_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import hct_pkg::*;

  logic [SEG_W-1:0] seg_r;
  logic [SEG_W-1:0] seg_nxt;
  logic             reg_hit;
  logic             wr_en;
  ctl_t             ctl;
  sts_t             sts;

  assign pready  = 1'b1;
  assign reg_hit = paddr[2:2] == REG_SEG_COUNT;
  assign wr_en   = psel && penable && pwrite && pready && reg_hit;
  assign seg_nxt = (pwdata[SEG_W-1:0] > MAX_SEGMENTS) ? MAX_SEGMENTS : pwdata[SEG_W-1:0];
  assign prdata  = reg_hit ? {{(DATA_W-SEG_W){1'b0}}, seg_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= SEG_RESET;
    end else if (wr_en) begin
      seg_r <= seg_nxt;
    end
  end

  assign in_stall = !ctl.idle;

  hct_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .ctl   (ctl)
  );

  hct_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .seg_count (seg_r),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
